@@ sv/crsfr_pkg.sv @@
// crsfr_pkg: shared types and constants of the crsf frame receiver
// no dependencies; used by crsfr_crc8 and crsf_frame_receiver_top

package crsfr_pkg;

  // frame geometry
  localparam int FRAME_BYTES = 64;
  localparam int CHANNELS    = 16;
  localparam int ADDR_W      = $clog2(FRAME_BYTES);

  // address bytes that open a frame
  localparam logic [7:0] ADDR_FC       = 8'hC8;
  localparam logic [7:0] ADDR_RADIO    = 8'hEC;
  localparam logic [7:0] ADDR_RX       = 8'hEA;
  localparam logic [7:0] ADDR_BCAST    = 8'h00;

  // length byte limits and minimum lengths of known frames
  localparam logic [7:0] LEN_MIN       = 8'd2;
  localparam logic [7:0] LEN_MAX       = 8'd62;
  localparam logic [5:0] RC_MIN_LEN    = 6'd24;
  localparam logic [5:0] LINK_MIN_LEN  = 6'd12;

  // frame types
  localparam logic [7:0] TYPE_RC       = 8'h16;
  localparam logic [7:0] TYPE_LINK     = 8'h14;

  // crc polynomial
  localparam logic [7:0] CRC_POLY      = 8'hD5;

  // channel scaling
  localparam logic [10:0]       RAW_MASK = 11'h7FF;
  localparam logic signed [15:0] US_MID  = 16'sd992;
  localparam logic signed [15:0] US_BASE = 16'sd1500;

  // payload byte positions inside the frame store
  localparam logic [ADDR_W-1:0] POS_PAYLOAD = ADDR_W'(3);
  localparam logic [ADDR_W-1:0] POS_LINK_END = ADDR_W'(9);

  // result kinds
  typedef enum logic [1:0] {
    KIND_RC   = 2'd0,
    KIND_LINK = 2'd1,
    KIND_CRC  = 2'd2
  } kind_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CRC,
    ST_CHECK,
    ST_RC_FETCH,
    ST_RC_MERGE,
    ST_RC_EMIT,
    ST_LK_FETCH,
    ST_LK_MERGE,
    ST_LK_EMIT,
    ST_OUT
  } state_t;

  // control into the crc unit
  typedef struct packed {
    logic       clear;
    logic       start;
    logic [7:0] data;
  } crc_ctrl_t;

  // status out of the crc unit
  typedef struct packed {
    logic       busy;
    logic [7:0] crc;
  } crc_stat_t;

endpackage

@@ sv/crsfr_crc8.sv @@
// crsfr_crc8: bit-serial crc-8 unit, one shift per cycle, eight per byte
// depends on crsfr_pkg (crc_ctrl_t, crc_stat_t, CRC_POLY)

module crsfr_crc8 (
  input  logic                 clk,
  input  logic                 rst_n,
  input  crsfr_pkg::crc_ctrl_t ctrl,
  output crsfr_pkg::crc_stat_t stat
);

  logic [7:0] crc_r, crc_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       busy_r, busy_nxt;

  // fold a byte in, then shift out one bit per cycle
  always_comb begin
    crc_nxt  = crc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (ctrl.clear) begin
      crc_nxt  = '0;
      busy_nxt = 1'b0;
    end else if (ctrl.start) begin
      crc_nxt  = crc_r ^ ctrl.data;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      crc_nxt = crc_r[7] ? ({crc_r[6:0], 1'b0} ^ crsfr_pkg::CRC_POLY)
                         : {crc_r[6:0], 1'b0};
      cnt_nxt = cnt_r + 3'd1;
      if (cnt_r == 3'd7) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r  <= '0;
      cnt_r  <= '0;
      busy_r <= 1'b0;
    end else begin
      crc_r  <= crc_nxt;
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.crc  = crc_r;

endmodule

@@ sv/crsf_frame_receiver_top.sv @@
// crsf_frame_receiver_top: byte-serial crsf frame receiver with crc check and unpack
// depends on crsfr_pkg and crsfr_crc8
//
//   channel | ports            | payload
//   --------+------------------+---------------------------------------------
//   input   | in_t*            | tdata: rx_byte
//   result  | out_t*           | tdata: channel and link fields, tuser: kind,
//           |                  | tlast: last result of the frame
//
// header bytes are taken in idle; each later byte passes idle, crc shifts and status
// after the crc byte comes a check state; an rc frame then reads 22 payload bytes (fetch,
// merge) and emits each channel (emit, transfer); a link frame reads 7 bytes and emits
// its result (emit, transfer); low out_tready stretches each transfer
// in_tready is low while a byte's crc shifts and until a frame's last result transfers
// reset is synchronous and clears control state and counters

module crsf_frame_receiver_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] rx_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  // [3:0] chan_num, [14:4] chan_code, [26:15] pulse_us,
  // [35:27] ant_rssi, [43:36] lq, [51:44] snr_db, [59:52] rf_mode,
  // [67:60] tx_pwr_sel, [99:68] frame_count, [131:100] crc_fail_total,
  // [135:132] zero
  output logic [135:0] out_tdata,
  output logic [1:0]   out_tuser,  // [1:0] result_kind
  output logic         out_tlast   // last_of_run
);

  localparam int AW = crsfr_pkg::ADDR_W;
  localparam int LK_BYTES = 7;

  // link byte slots after the seven reads (positions 3 to 9)
  localparam int LK_RSSI1 = 0;
  localparam int LK_RSSI2 = 1;
  localparam int LK_LQ    = 2;
  localparam int LK_SNR   = 3;
  localparam int LK_ANT   = 4;
  localparam int LK_RF    = 5;
  localparam int LK_TX    = 6;

  crsfr_pkg::state_t state_r, state_nxt;

  logic [6:0]  pos_r, pos_nxt;
  logic [6:0]  exp_r, exp_nxt;
  logic [5:0]  len_r, len_nxt;
  logic [7:0]  type_r, type_nxt;
  logic        last_r, last_nxt;
  logic [31:0] rc_cnt_r, rc_cnt_nxt;
  logic [31:0] lk_cnt_r, lk_cnt_nxt;
  logic [31:0] crc_cnt_r, crc_cnt_nxt;

  logic [AW-1:0] rd_addr_r, rd_addr_nxt;
  logic [17:0]   acc_r, acc_nxt;
  logic [4:0]    bits_r, bits_nxt;
  logic [3:0]    ch_r, ch_nxt;
  logic [7:0]    lk_r   [LK_BYTES];
  logic [7:0]    lk_nxt [LK_BYTES];

  // result register
  crsfr_pkg::kind_t   o_kind_r, o_kind_nxt;
  logic [3:0]         o_idx_r, o_idx_nxt;
  logic [10:0]        o_raw_r, o_raw_nxt;
  logic [11:0]        o_us_r, o_us_nxt;
  logic [8:0]         o_rssi_r, o_rssi_nxt;
  logic [7:0]         o_lq_r, o_lq_nxt;
  logic [7:0]         o_snr_r, o_snr_nxt;
  logic [7:0]         o_rf_r, o_rf_nxt;
  logic [7:0]         o_tx_r, o_tx_nxt;
  logic [31:0]        o_fc_r, o_fc_nxt;
  logic [31:0]        o_cc_r, o_cc_nxt;
  logic               o_last_r, o_last_nxt;

  // frame store
  logic [7:0] mem [crsfr_pkg::FRAME_BYTES];
  logic [7:0] rd_data_r;
  logic       wr_en;

  crsfr_pkg::crc_ctrl_t crc_ctrl;
  crsfr_pkg::crc_stat_t crc_stat;

  logic        in_xfer, out_xfer, addr_ok;
  logic [10:0] raw;
  logic signed [15:0] us_d, us_p, us_q, us_v;
  logic [7:0]  rssi_sel;

  assign in_tready = (state_r == crsfr_pkg::ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_tvalid = (state_r == crsfr_pkg::ST_OUT);
  assign out_xfer  = out_tvalid && out_tready;

  assign addr_ok = (in_tdata == crsfr_pkg::ADDR_FC) || (in_tdata == crsfr_pkg::ADDR_RADIO) ||
                   (in_tdata == crsfr_pkg::ADDR_RX) || (in_tdata == crsfr_pkg::ADDR_BCAST);

  // store write for every byte from the type byte on
  assign wr_en = in_xfer && (pos_r >= 7'd2);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[pos_r[AW-1:0]] <= in_tdata;
    end
    rd_data_r <= mem[rd_addr_r];
  end

  crsfr_crc8 u_crc (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (crc_ctrl),
    .stat  (crc_stat)
  );

  // channel to microseconds, division by 8 truncating toward zero
  assign raw  = acc_r[10:0] & crsfr_pkg::RAW_MASK;
  assign us_d = $signed({5'b0, raw}) - crsfr_pkg::US_MID;
  assign us_p = (us_d <<< 2) + us_d;
  assign us_q = (us_p + (us_p[15] ? 16'sd7 : 16'sd0)) >>> 3;
  assign us_v = us_q + crsfr_pkg::US_BASE;

  // rssi of the active antenna
  assign rssi_sel = (lk_r[LK_ANT] == 8'd0) ? lk_r[LK_RSSI1] : lk_r[LK_RSSI2];

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    pos_nxt     = pos_r;
    exp_nxt     = exp_r;
    len_nxt     = len_r;
    type_nxt    = type_r;
    last_nxt    = last_r;
    rc_cnt_nxt  = rc_cnt_r;
    lk_cnt_nxt  = lk_cnt_r;
    crc_cnt_nxt = crc_cnt_r;
    rd_addr_nxt = rd_addr_r;
    acc_nxt     = acc_r;
    bits_nxt    = bits_r;
    ch_nxt      = ch_r;
    lk_nxt      = lk_r;
    o_kind_nxt  = o_kind_r;
    o_idx_nxt   = o_idx_r;
    o_raw_nxt   = o_raw_r;
    o_us_nxt    = o_us_r;
    o_rssi_nxt  = o_rssi_r;
    o_lq_nxt    = o_lq_r;
    o_snr_nxt   = o_snr_r;
    o_rf_nxt    = o_rf_r;
    o_tx_nxt    = o_tx_r;
    o_fc_nxt    = o_fc_r;
    o_cc_nxt    = o_cc_r;
    o_last_nxt  = o_last_r;
    crc_ctrl    = '{clear: 1'b0, start: 1'b0, data: in_tdata};

    unique case (state_r)
      crsfr_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (pos_r == 7'd0) begin
            // hunting for an address byte
            if (addr_ok) begin
              pos_nxt = 7'd1;
            end
          end else if (pos_r == 7'd1) begin
            // length byte
            if ((in_tdata < crsfr_pkg::LEN_MIN) || (in_tdata > crsfr_pkg::LEN_MAX)) begin
              pos_nxt = 7'd0;
              exp_nxt = 7'd0;
            end else begin
              len_nxt        = in_tdata[5:0];
              exp_nxt        = in_tdata[6:0] + 7'd2;
              pos_nxt        = 7'd2;
              crc_ctrl.clear = 1'b1;
            end
          end else begin
            // frame body: fold into the crc, crc byte included
            if (pos_r == 7'd2) begin
              type_nxt = in_tdata;
            end
            crc_ctrl.start = 1'b1;
            last_nxt       = ((pos_r + 7'd1) >= exp_r);
            pos_nxt        = pos_r + 7'd1;
            state_nxt      = crsfr_pkg::ST_CRC;
          end
        end
      end

      crsfr_pkg::ST_CRC: begin
        if (!crc_stat.busy) begin
          if (last_r) begin
            pos_nxt   = 7'd0;
            exp_nxt   = 7'd0;
            state_nxt = crsfr_pkg::ST_CHECK;
          end else begin
            state_nxt = crsfr_pkg::ST_IDLE;
          end
        end
      end

      crsfr_pkg::ST_CHECK: begin
        // a matching crc byte leaves a zero remainder
        o_idx_nxt  = '0;
        o_raw_nxt  = '0;
        o_us_nxt   = '0;
        o_rssi_nxt = '0;
        o_lq_nxt   = '0;
        o_snr_nxt  = '0;
        o_rf_nxt   = '0;
        o_tx_nxt   = '0;
        rd_addr_nxt = crsfr_pkg::POS_PAYLOAD;
        acc_nxt     = '0;
        bits_nxt    = '0;
        ch_nxt      = '0;
        if (crc_stat.crc != 8'd0) begin
          crc_cnt_nxt = crc_cnt_r + 32'd1;
          o_kind_nxt  = crsfr_pkg::KIND_CRC;
          o_fc_nxt    = '0;
          o_cc_nxt    = crc_cnt_r + 32'd1;
          o_last_nxt  = 1'b1;
          state_nxt   = crsfr_pkg::ST_OUT;
        end else if ((type_r == crsfr_pkg::TYPE_RC) && (len_r >= crsfr_pkg::RC_MIN_LEN)) begin
          rc_cnt_nxt = rc_cnt_r + 32'd1;
          state_nxt  = crsfr_pkg::ST_RC_FETCH;
        end else if ((type_r == crsfr_pkg::TYPE_LINK) &&
                     (len_r >= crsfr_pkg::LINK_MIN_LEN)) begin
          lk_cnt_nxt = lk_cnt_r + 32'd1;
          state_nxt  = crsfr_pkg::ST_LK_FETCH;
        end else begin
          state_nxt = crsfr_pkg::ST_IDLE;
        end
      end

      // store read is in flight
      crsfr_pkg::ST_RC_FETCH: begin
        state_nxt = crsfr_pkg::ST_RC_MERGE;
      end

      crsfr_pkg::ST_RC_MERGE: begin
        acc_nxt     = acc_r | (18'(rd_data_r) << bits_r);
        bits_nxt    = bits_r + 5'd8;
        rd_addr_nxt = rd_addr_r + AW'(1);
        state_nxt   = ((bits_r + 5'd8) >= 5'd11) ? crsfr_pkg::ST_RC_EMIT
                                                 : crsfr_pkg::ST_RC_FETCH;
      end

      crsfr_pkg::ST_RC_EMIT: begin
        o_kind_nxt = crsfr_pkg::KIND_RC;
        o_idx_nxt  = ch_r;
        o_raw_nxt  = raw;
        o_us_nxt   = us_v[11:0];
        o_fc_nxt   = rc_cnt_r;
        o_cc_nxt   = crc_cnt_r;
        o_last_nxt = (ch_r == 4'(crsfr_pkg::CHANNELS - 1));
        acc_nxt    = acc_r >> 11;
        bits_nxt   = bits_r - 5'd11;
        state_nxt  = crsfr_pkg::ST_OUT;
      end

      crsfr_pkg::ST_LK_FETCH: begin
        state_nxt = crsfr_pkg::ST_LK_MERGE;
      end

      crsfr_pkg::ST_LK_MERGE: begin
        for (int i = 0; i < LK_BYTES - 1; i++) begin
          lk_nxt[i] = lk_r[i+1];
        end
        lk_nxt[LK_BYTES-1] = rd_data_r;
        rd_addr_nxt = rd_addr_r + AW'(1);
        state_nxt   = (rd_addr_r == crsfr_pkg::POS_LINK_END) ? crsfr_pkg::ST_LK_EMIT
                                                             : crsfr_pkg::ST_LK_FETCH;
      end

      crsfr_pkg::ST_LK_EMIT: begin
        o_kind_nxt = crsfr_pkg::KIND_LINK;
        o_rssi_nxt = 9'd0 - {1'b0, rssi_sel};
        o_lq_nxt   = lk_r[LK_LQ];
        o_snr_nxt  = lk_r[LK_SNR];
        o_rf_nxt   = lk_r[LK_RF];
        o_tx_nxt   = lk_r[LK_TX];
        o_fc_nxt   = lk_cnt_r;
        o_cc_nxt   = crc_cnt_r;
        o_last_nxt = 1'b1;
        state_nxt  = crsfr_pkg::ST_OUT;
      end

      crsfr_pkg::ST_OUT: begin
        if (out_xfer) begin
          if (o_last_r) begin
            state_nxt = crsfr_pkg::ST_IDLE;
          end else begin
            ch_nxt    = ch_r + 4'd1;
            state_nxt = (bits_r >= 5'd11) ? crsfr_pkg::ST_RC_EMIT
                                          : crsfr_pkg::ST_RC_FETCH;
          end
        end
      end

      default: begin
        state_nxt = crsfr_pkg::ST_IDLE;
      end
    endcase
  end

  // control state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= crsfr_pkg::ST_IDLE;
      pos_r     <= '0;
      exp_r     <= '0;
      last_r    <= 1'b0;
      rc_cnt_r  <= '0;
      lk_cnt_r  <= '0;
      crc_cnt_r <= '0;
      ch_r      <= '0;
      bits_r    <= '0;
      o_last_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      pos_r     <= pos_nxt;
      exp_r     <= exp_nxt;
      last_r    <= last_nxt;
      rc_cnt_r  <= rc_cnt_nxt;
      lk_cnt_r  <= lk_cnt_nxt;
      crc_cnt_r <= crc_cnt_nxt;
      ch_r      <= ch_nxt;
      bits_r    <= bits_nxt;
      o_last_r  <= o_last_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    len_r     <= len_nxt;
    type_r    <= type_nxt;
    rd_addr_r <= rd_addr_nxt;
    acc_r     <= acc_nxt;
    lk_r      <= lk_nxt;
    o_kind_r  <= o_kind_nxt;
    o_idx_r   <= o_idx_nxt;
    o_raw_r   <= o_raw_nxt;
    o_us_r    <= o_us_nxt;
    o_rssi_r  <= o_rssi_nxt;
    o_lq_r    <= o_lq_nxt;
    o_snr_r   <= o_snr_nxt;
    o_rf_r    <= o_rf_nxt;
    o_tx_r    <= o_tx_nxt;
    o_fc_r    <= o_fc_nxt;
    o_cc_r    <= o_cc_nxt;
  end

  // result packing
  assign out_tdata = {4'b0, o_cc_r, o_fc_r, o_tx_r, o_rf_r, o_snr_r, o_lq_r,
                      o_rssi_r, o_us_r, o_raw_r, o_idx_r};
  assign out_tuser = o_kind_r;
  assign out_tlast = o_last_r;

endmodule

@@ verif/crsf_frame_receiver_top_test.sv @@
// crsf_frame_receiver_top_test: self-checking bench for the crsf frame receiver
// streams framed and malformed bytes in, predicts every result transfer and compares it
// depends on crsfr_pkg and crsf_frame_receiver_top

module crsf_frame_receiver_top_test;
  import crsfr_pkg::*;

  localparam int LIMIT        = 400000;
  localparam int DRAIN_CYCLES = 64;
  localparam int TAIL_BYTES   = 60;
  localparam int TOTAL_BYTES  = 270;

  // one predicted result transfer
  typedef struct packed {
    kind_t       kind;
    logic [3:0]  ch_idx;
    logic [10:0] raw;
    logic [11:0] us;
    logic [8:0]  rssi;
    logic [7:0]  lq;
    logic [7:0]  snr;
    logic [7:0]  rf_mode;
    logic [7:0]  tx_power;
    logic [31:0] count;
    logic [31:0] crc_cnt;
    logic        last;
  } frame_report_t;

  // one byte waiting to be sent; hold makes the sender wait for all results first
  typedef struct {
    logic [7:0] value;
    bit         hold;
  } rx_item_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = 8'h00;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [135:0] out_tdata;
  logic [1:0]   out_tuser;
  logic         out_tlast;

  rx_item_t      pending_bytes[$];
  frame_report_t report_queue[$];
  logic [7:0]    payload_buf[0:63];

  // receiver shadow state
  logic [7:0]  rx_store[0:63];
  logic [6:0]  rx_pos = '0;
  logic [6:0]  rx_size = '0;
  logic [31:0] rc_frames = '0;
  logic [31:0] link_frames = '0;
  logic [31:0] crc_errors = '0;

  int bytes_sent = 0;
  int bytes_taken = 0;
  int src_gap = 0;
  int sink_gap = 0;
  int cycle_count = 0;
  int fail_count = 0;
  int rc_seen = 0;
  int link_seen = 0;
  int crc_seen = 0;
  bit quiet_phase = 1'b0;

  crsf_frame_receiver_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // one byte step of crc-8, polynomial 0xd5, msb first
  function automatic logic [7:0] crc_d5_step(input logic [7:0] crc_in, input logic [7:0] b);
    logic [7:0] c;
    c = crc_in ^ b;
    for (int k = 0; k < 8; k++) c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    return c;
  endfunction

  // advance the shadow receiver by one accepted byte and queue its results
  task automatic predict_rx_byte(input logic [7:0] b);
    frame_report_t r;
    logic [7:0]    len;
    logic [7:0]    crc;
    logic [7:0]    rssi_b;
    logic [10:0]   raw;
    logic [31:0]   acc;
    int            bits;
    int            pos;
    int            us;
    if (rx_pos == 0) begin
      // hunting for an address byte
      if (b == ADDR_FC || b == ADDR_RADIO || b == ADDR_RX || b == ADDR_BCAST) begin
        rx_store[0] = b;
        rx_pos = 7'd1;
      end
    end else if (rx_pos == 1) begin
      // length byte; out of range drops the frame
      if (b < LEN_MIN || b > LEN_MAX) begin
        rx_pos = '0;
        rx_size = '0;
      end else begin
        rx_store[1] = b;
        rx_size = 7'(b + 8'd2);
        rx_pos = 7'd2;
      end
    end else begin
      rx_store[rx_pos[5:0]] = b;
      rx_pos = rx_pos + 7'd1;
      if (rx_pos >= rx_size) begin
        rx_pos = '0;
        rx_size = '0;
        len = rx_store[1];
        crc = 8'h00;
        for (int i = 2; i <= len; i++) crc = crc_d5_step(crc, rx_store[i]);
        if (rx_store[len + 1] != crc) begin
          // crc mismatch
          crc_errors = crc_errors + 32'd1;
          r = '0;
          r.kind = KIND_CRC;
          r.crc_cnt = crc_errors;
          r.last = 1'b1;
          report_queue.push_back(r);
        end else if (rx_store[2] == TYPE_RC && len >= RC_MIN_LEN) begin
          // unpack 11-bit channels lsb first
          rc_frames = rc_frames + 32'd1;
          acc = '0;
          bits = 0;
          pos = int'(POS_PAYLOAD);
          for (int ch = 0; ch < CHANNELS; ch++) begin
            while (bits < 11) begin
              acc = acc | (32'(rx_store[pos]) << bits);
              pos++;
              bits += 8;
            end
            raw = acc[10:0] & RAW_MASK;
            acc = acc >> 11;
            bits -= 11;
            us = ((int'(raw) - int'(US_MID)) * 5) / 8 + int'(US_BASE);
            r = '0;
            r.kind = KIND_RC;
            r.ch_idx = 4'(ch);
            r.raw = raw;
            r.us = us[11:0];
            r.count = rc_frames;
            r.crc_cnt = crc_errors;
            r.last = (ch == CHANNELS - 1);
            report_queue.push_back(r);
          end
        end else if (rx_store[2] == TYPE_LINK && len >= LINK_MIN_LEN) begin
          // link statistics; rssi from the active antenna
          link_frames = link_frames + 32'd1;
          rssi_b = (rx_store[7] == 8'h00) ? rx_store[3] : rx_store[4];
          r = '0;
          r.kind = KIND_LINK;
          r.rssi = 9'd0 - {1'b0, rssi_b};
          r.lq = rx_store[5];
          r.snr = rx_store[6];
          r.rf_mode = rx_store[8];
          r.tx_power = rx_store[9];
          r.count = link_frames;
          r.crc_cnt = crc_errors;
          r.last = 1'b1;
          report_queue.push_back(r);
        end
      end
    end
  endtask

  task automatic queue_byte(input logic [7:0] b, input bit hold);
    rx_item_t it;
    it.value = b;
    it.hold = hold;
    pending_bytes.push_back(it);
  endtask

  task automatic fill_payload(input logic [7:0] value, input bit random_fill);
    for (int i = 0; i < 64; i++) payload_buf[i] = random_fill ? 8'($urandom) : value;
  endtask

  // address, length, type, payload_buf, crc (optionally damaged)
  task automatic queue_frame(input logic [7:0] addr, input logic [7:0] len,
                             input logic [7:0] ftype, input bit corrupt, input bit hold);
    logic [7:0] crc;
    crc = crc_d5_step(8'h00, ftype);
    queue_byte(addr, hold);
    queue_byte(len, 1'b0);
    queue_byte(ftype, 1'b0);
    for (int i = 0; i < int'(len) - 2; i++) begin
      queue_byte(payload_buf[i], 1'b0);
      crc = crc_d5_step(crc, payload_buf[i]);
    end
    if (corrupt) crc = crc ^ 8'($urandom_range(1, 255));
    queue_byte(crc, 1'b0);
  endtask

  function automatic logic [7:0] pick_addr();
    case ($urandom_range(0, 3))
      0: return ADDR_FC;
      1: return ADDR_RADIO;
      2: return ADDR_RX;
      default: return ADDR_BCAST;
    endcase
  endfunction

  // sender: presents pending bytes at the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && bytes_sent != bytes_taken) begin
      // transfer still open, hold the byte
    end else if (src_gap > 0) begin
      in_tvalid <= 1'b0;
      src_gap <= src_gap - 1;
    end else if (pending_bytes.size() == 0) begin
      in_tvalid <= 1'b0;
    end else if (pending_bytes[0].hold && report_queue.size() != 0) begin
      in_tvalid <= 1'b0;
    end else if (!quiet_phase && pending_bytes.size() >= TAIL_BYTES &&
                 $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      src_gap <= $urandom_range(0, 14);
    end else begin
      in_tdata <= pending_bytes[0].value;
      in_tvalid <= 1'b1;
      bytes_sent <= bytes_sent + 1;
      pending_bytes.pop_front();
    end
  end

  // receiver side backpressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (sink_gap > 0) begin
      out_tready <= 1'b0;
      sink_gap <= sink_gap - 1;
    end else if (!quiet_phase && pending_bytes.size() >= TAIL_BYTES &&
                 $urandom_range(0, 4) == 0) begin
      out_tready <= 1'b0;
      sink_gap <= $urandom_range(0, 14);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // monitor: predict on input transfers, check on result transfers
  always @(posedge clk) begin
    frame_report_t want;
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end else begin
      if (cycle_count % 256 == 0) quiet_phase <= ($urandom_range(0, 3) == 0);
      if (rst_n && in_tvalid && in_tready) begin
        predict_rx_byte(in_tdata);
        bytes_taken <= bytes_taken + 1;
      end
      if (rst_n && out_tvalid && out_tready) begin
        if (report_queue.size() == 0) begin
          $error("result transfer with nothing expected: kind %0d", out_tuser);
          fail_count++;
        end else begin
          want = report_queue.pop_front();
          case (want.kind)
            KIND_RC:   rc_seen++;
            KIND_LINK: link_seen++;
            default:   crc_seen++;
          endcase
          if (out_tuser !== want.kind) begin
            $error("result_kind: expected %0d, got %0d", want.kind, out_tuser);
            fail_count++;
          end
          if (out_tdata[3:0] !== want.ch_idx) begin
            $error("chan_num: expected %0d, got %0d", want.ch_idx, out_tdata[3:0]);
            fail_count++;
          end
          if (out_tdata[14:4] !== want.raw) begin
            $error("chan_code: expected %0d, got %0d", want.raw, out_tdata[14:4]);
            fail_count++;
          end
          if (out_tdata[26:15] !== want.us) begin
            $error("pulse_us: expected %0d, got %0d", want.us, out_tdata[26:15]);
            fail_count++;
          end
          if (out_tdata[35:27] !== want.rssi) begin
            $error("ant_rssi: expected %0d, got %0d",
                   $signed(want.rssi), $signed(out_tdata[35:27]));
            fail_count++;
          end
          if (out_tdata[43:36] !== want.lq) begin
            $error("lq: expected %0d, got %0d", want.lq, out_tdata[43:36]);
            fail_count++;
          end
          if (out_tdata[51:44] !== want.snr) begin
            $error("snr_db: expected %0d, got %0d",
                   $signed(want.snr), $signed(out_tdata[51:44]));
            fail_count++;
          end
          if (out_tdata[59:52] !== want.rf_mode) begin
            $error("rf_mode: expected %0d, got %0d", want.rf_mode, out_tdata[59:52]);
            fail_count++;
          end
          if (out_tdata[67:60] !== want.tx_power) begin
            $error("tx_pwr_sel: expected %0d, got %0d", want.tx_power, out_tdata[67:60]);
            fail_count++;
          end
          if (out_tdata[99:68] !== want.count) begin
            $error("frame_count: expected %0d, got %0d", want.count, out_tdata[99:68]);
            fail_count++;
          end
          if (out_tdata[131:100] !== want.crc_cnt) begin
            $error("crc_fail_total: expected %0d, got %0d", want.crc_cnt, out_tdata[131:100]);
            fail_count++;
          end
          if (out_tlast !== want.last) begin
            $error("last_of_run: expected %0d, got %0d", want.last, out_tlast);
            fail_count++;
          end
        end
      end
    end
  end

  // stimulus, reset, end of run
  initial begin
    int         sel;
    int         results_built;
    bit         hold;
    logic [7:0] len;
    logic [7:0] ftype;
    logic [7:0] b;

    // hunting drops non-address bytes
    queue_byte(8'h01, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h7F, 1'b0);
    // bad length bytes on each address
    queue_byte(ADDR_FC, 1'b0);
    queue_byte(8'd1, 1'b0);
    queue_byte(ADDR_RADIO, 1'b0);
    queue_byte(8'd63, 1'b0);
    queue_byte(ADDR_RX, 1'b0);
    queue_byte(8'd255, 1'b0);
    queue_byte(ADDR_BCAST, 1'b0);
    queue_byte(8'd0, 1'b0);
    // rc frames: all channels at max, all at zero, longest frame
    fill_payload(8'hFF, 1'b0);
    queue_frame(ADDR_FC, 8'd24, TYPE_RC, 1'b0, 1'b0);
    fill_payload(8'h00, 1'b0);
    queue_frame(ADDR_BCAST, 8'd24, TYPE_RC, 1'b0, 1'b0);
    fill_payload(8'h00, 1'b1);
    queue_frame(ADDR_RX, LEN_MAX, TYPE_RC, 1'b0, 1'b1);
    // link frames: rssi from antenna one then antenna two
    fill_payload(8'hFF, 1'b0);
    payload_buf[4] = 8'h00;
    queue_frame(ADDR_RADIO, 8'd12, TYPE_LINK, 1'b0, 1'b0);
    fill_payload(8'h00, 1'b0);
    payload_buf[4] = 8'h01;
    payload_buf[3] = 8'h80;
    queue_frame(ADDR_FC, 8'd12, TYPE_LINK, 1'b0, 1'b0);
    // crc errors
    fill_payload(8'h00, 1'b1);
    queue_frame(ADDR_FC, 8'd24, TYPE_RC, 1'b1, 1'b0);
    queue_frame(ADDR_RX, 8'd12, TYPE_LINK, 1'b1, 1'b0);
    // short known frames, minimal frame, unknown type
    queue_frame(ADDR_FC, 8'd23, TYPE_RC, 1'b0, 1'b0);
    queue_frame(ADDR_RADIO, 8'd11, TYPE_LINK, 1'b0, 1'b0);
    queue_frame(ADDR_BCAST, LEN_MIN, 8'h3A, 1'b0, 1'b0);
    queue_frame(ADDR_FC, 8'd6, 8'h28, 1'b0, 1'b1);

    // random part: mostly well-formed frames, some noise and broken frames
    results_built = 0;
    while (pending_bytes.size() < TOTAL_BYTES || results_built < 16) begin
      sel = $urandom_range(0, 99);
      hold = ($urandom_range(0, 19) == 0);
      fill_payload(8'h00, 1'b1);
      if (sel < 35) begin
        len = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(25, 62))
                                           : 8'($urandom_range(24, 26));
        queue_frame(pick_addr(), len, TYPE_RC, $urandom_range(0, 9) == 0, hold);
        results_built += 16;
      end else if (sel < 60) begin
        len = 8'($urandom_range(12, 16));
        if ($urandom_range(0, 1) == 0) payload_buf[4] = 8'h00;
        queue_frame(pick_addr(), len, TYPE_LINK, $urandom_range(0, 9) == 0, hold);
        results_built++;
      end else if (sel < 70) begin
        if ($urandom_range(0, 1) == 0)
          queue_frame(pick_addr(), 8'($urandom_range(2, 23)), TYPE_RC, 1'b0, hold);
        else
          queue_frame(pick_addr(), 8'($urandom_range(2, 11)), TYPE_LINK, 1'b0, hold);
      end else if (sel < 80) begin
        ftype = 8'($urandom);
        if (ftype == TYPE_RC || ftype == TYPE_LINK) ftype = ftype ^ 8'h01;
        queue_frame(pick_addr(), 8'($urandom_range(2, 10)), ftype, 1'b0, hold);
      end else if (sel < 90) begin
        // noise that never opens a frame
        repeat ($urandom_range(1, 6)) begin
          b = 8'($urandom);
          if (b == ADDR_FC || b == ADDR_RADIO || b == ADDR_RX || b == ADDR_BCAST)
            b = b ^ 8'h01;
          queue_byte(b, 1'b0);
        end
      end else begin
        // address followed by an out of range length
        queue_byte(pick_addr(), hold);
        queue_byte(($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 1))
                                                : 8'($urandom_range(63, 255)), 1'b0);
      end
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_bytes.size() != 0 || bytes_sent != bytes_taken || report_queue.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d bytes; checked %0d rc channel, %0d link statistics, %0d crc error results",
             bytes_taken, rc_seen, link_seen, crc_seen);
    $display("frames seen by the bench: %0d rc, %0d link, %0d failed crc",
             rc_frames, link_frames, crc_errors);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
